@@ hdl/wos_pkg.sv @@
// Shared types, widths, constants and helper functions for the walk-on-spheres step core.
package wos_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int ANGLE_BITS = 16;
  localparam int COUNT_BITS = 22;

  // Field and register widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;
  localparam int START_W    = 30;
  localparam int SHOT_W     = 22;
  localparam int EPS_W      = 29;
  localparam int HIT_W      = 22;
  localparam int RATIO_W    = 17;

  localparam int IN_DATA_W  = ((ANGLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((HIT_W + RATIO_W + 7) / 8) * 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOTS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS     = 2'd3;

  localparam logic [SHOT_W-1:0] SHOT_RESET = SHOT_W'(1000000);
  localparam logic [EPS_W-1:0]  EPS_RESET  = EPS_W'(268);

  // Datapath widths
  localparam int POS_W     = FRAC_BITS + 4;
  localparam int EXT_W     = POS_W + 2;
  localparam int HYP_SHIFT = (FRAC_BITS > 28) ? FRAC_BITS - 28 : 0;
  localparam int CFG_LSH   = (FRAC_BITS > 28) ? FRAC_BITS - 28 : 0;
  localparam int CFG_RSH   = (FRAC_BITS < 28) ? 28 - FRAC_BITS : 0;
  localparam int SQ_W      = FRAC_BITS - HYP_SHIFT + 4;
  localparam int NUM_W     = 2 * SQ_W;
  localparam int CORDIC_N  = 30;
  localparam int CORDIC_W  = 34;
  localparam int Z_W       = 32;
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_W     = COUNT_BITS + 16;
  localparam int IT_MAX    = (CORDIC_N > DIV_W) ? CORDIC_N : DIV_W;
  localparam int IT_W      = $clog2(IT_MAX + 1);

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

  localparam logic signed [EXT_W-1:0] ONE_E   = EXT_W'(1) << FRAC_BITS;
  localparam logic signed [EXT_W-1:0] TWO_E   = EXT_W'(2) << FRAC_BITS;
  localparam logic signed [EXT_W-1:0] THREE_E = EXT_W'(3) << FRAC_BITS;
  localparam logic signed [EXT_W-1:0] FOUR_E  = EXT_W'(4) << FRAC_BITS;
  localparam logic signed [EXT_W-1:0] TENTH_E =
    EXT_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  localparam logic signed [PROD_W-1:0] W_MAX_P =
    {{(PROD_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] W_MIN_P =
    {{(PROD_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQRT,
    ST_CHECK,
    ST_CORDIC,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Saturate to the walker range [-8, 8)
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
    logic signed [POS_W-1:0] res;
    if (v > W_MAX_P) res = W_MAX_P[POS_W-1:0];
    else if (v < W_MIN_P) res = W_MIN_P[POS_W-1:0];
    else res = v[POS_W-1:0];
    return res;
  endfunction

  // Rescale an unsigned Q2.28 register value to the walker format
  function automatic logic [POS_W-1:0] from_q28(input logic [START_W-1:0] v);
    logic [POS_W-1:0] res;
    res = POS_W'(v >> CFG_RSH) << CFG_LSH;
    return res;
  endfunction

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic signed [Z_W-1:0] atan_turn(input logic [IT_W-1:0] i);
    logic signed [Z_W-1:0] res;
    unique case (i)
      IT_W'(0):  res = Z_W'(536870912);
      IT_W'(1):  res = Z_W'(316933406);
      IT_W'(2):  res = Z_W'(167458907);
      IT_W'(3):  res = Z_W'(85004756);
      IT_W'(4):  res = Z_W'(42667331);
      IT_W'(5):  res = Z_W'(21354465);
      IT_W'(6):  res = Z_W'(10679838);
      IT_W'(7):  res = Z_W'(5340245);
      IT_W'(8):  res = Z_W'(2670163);
      IT_W'(9):  res = Z_W'(1335087);
      IT_W'(10): res = Z_W'(667544);
      IT_W'(11): res = Z_W'(333772);
      IT_W'(12): res = Z_W'(166886);
      IT_W'(13): res = Z_W'(83443);
      IT_W'(14): res = Z_W'(41722);
      IT_W'(15): res = Z_W'(20861);
      IT_W'(16): res = Z_W'(10430);
      IT_W'(17): res = Z_W'(5215);
      IT_W'(18): res = Z_W'(2608);
      IT_W'(19): res = Z_W'(1304);
      IT_W'(20): res = Z_W'(652);
      IT_W'(21): res = Z_W'(326);
      IT_W'(22): res = Z_W'(163);
      IT_W'(23): res = Z_W'(81);
      IT_W'(24): res = Z_W'(41);
      IT_W'(25): res = Z_W'(20);
      IT_W'(26): res = Z_W'(10);
      IT_W'(27): res = Z_W'(5);
      IT_W'(28): res = Z_W'(3);
      IT_W'(29): res = Z_W'(1);
      default:   res = '0;
    endcase
    return res;
  endfunction

endpackage

@@ hdl/walk_on_spheres_step_core.sv @@
// Walk-on-spheres walker: one fold, distance and move step per input angle.
// Each accepted angle runs one walk step through a small sequencer around a shared
// multiplier, a bit-serial square root, a CORDIC rotator and a restoring divider.
// A step with the walker at x > 2 runs range, check, 30 CORDIC iterations and 4
// multiplies; at x <= 2 two corner distances add 2 squares and a square root each.
// An absorbing step skips the CORDIC; the step that ends a run adds a divide for
// the ratio before the result is placed in the output register. in_tready is high
// only while the core is idle and no register write is presented; a pending result
// does not block the next step unless another run ends first.
module walk_on_spheres_step_core import wos_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [ANGLE_BITS-1:0] angle
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [21:0] hit_count, [38:22] hit_ratio
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [START_W-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [SHOT_W-1:0]  shot_total_r, shot_total_nxt;
  logic [EPS_W-1:0]   eps_r, eps_nxt;

  logic signed [POS_W-1:0] walker_x_r, walker_x_nxt, walker_y_r, walker_y_nxt;
  logic [COUNT_BITS-1:0]   shots_r, shots_nxt, hits_r, hits_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Payload registers
  logic signed [POS_W-1:0]    x_r, x_nxt, y_r, y_nxt, r_r, r_nxt;
  logic [ANGLE_BITS-1:0]      angle_r, angle_nxt;
  logic                       corner_r, corner_nxt;
  logic [NUM_W-1:0]           num_r, num_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic signed [CORDIC_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [Z_W-1:0]      cz_r, cz_nxt;
  logic [1:0]                 quad_r, quad_nxt;
  logic [IT_W-1:0]            it_r, it_nxt;
  logic signed [CORDIC_W-1:0] sin_r, sin_nxt, cos_r, cos_nxt;
  logic [1:0]                 mstep_r, mstep_nxt;
  logic signed [PROD_W-1:0]   acc_r, acc_nxt;
  logic [SHOT_W-1:0]          rem_r, rem_nxt;
  logic [DIV_W-1:0]           quo_r, quo_nxt;
  logic [HIT_W-1:0]           hit_out_r, hit_out_nxt;
  logic [OUT_DATA_W-1:0]      out_data_r, out_data_nxt;

  // Shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  assign prod = mul_a * mul_b;

  // Combinational helpers
  logic signed [EXT_W-1:0] wx_e, wy_e, x_e, y_e, dx_e, dy_e, c1, c2;
  logic [EXT_W-1:0]        adx, ady;
  logic [SQ_W-1:0]         ax, ay;
  logic [NUM_W-1:0]        trial;
  logic [POS_W:0]          dval;
  logic signed [POS_W-1:0] dist_s, eps_s;
  logic [COUNT_BITS-1:0]   hits_new, shots_new;
  logic [SHOT_W-1:0]       total;
  logic [SHOT_W:0]         div_sh;
  logic signed [CORDIC_W-1:0] sh_x, sh_y;
  logic signed [PROD_W-1:0] mul_sum, pos_sum;
  logic                    accept;

  assign in_tready  = (state_r == ST_IDLE) && !cfg_wr_en;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign total      = (shot_total_r == '0) ? SHOT_W'(1) : shot_total_r;

  always_comb begin
    state_nxt      = state_r;
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    shot_total_nxt = shot_total_r;
    eps_nxt        = eps_r;
    walker_x_nxt   = walker_x_r;
    walker_y_nxt   = walker_y_r;
    shots_nxt      = shots_r;
    hits_nxt       = hits_r;
    out_valid_nxt  = out_valid_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    r_nxt          = r_r;
    angle_nxt      = angle_r;
    corner_nxt     = corner_r;
    num_nxt        = num_r;
    res_nxt        = res_r;
    bit_nxt        = bit_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    quad_nxt       = quad_r;
    it_nxt         = it_r;
    sin_nxt        = sin_r;
    cos_nxt        = cos_r;
    mstep_nxt      = mstep_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    hit_out_nxt    = hit_out_r;
    out_data_nxt   = out_data_r;
    mul_a          = '0;
    mul_b          = '0;

    wx_e = EXT_W'(walker_x_r);
    wy_e = EXT_W'(walker_y_r);
    x_e  = EXT_W'(x_r);
    y_e  = EXT_W'(y_r);
    dx_e = x_e - TWO_E;
    dy_e = y_e - (corner_r ? THREE_E : ONE_E);
    adx  = dx_e[EXT_W-1] ? EXT_W'(-dx_e) : EXT_W'(dx_e);
    ady  = dy_e[EXT_W-1] ? EXT_W'(-dy_e) : EXT_W'(dy_e);
    ax   = SQ_W'(adx >> HYP_SHIFT);
    ay   = SQ_W'(ady >> HYP_SHIFT);
    c1   = '0;
    c2   = '0;
    trial  = res_r + bit_r;
    dval   = '0;
    dist_s = '0;
    eps_s  = $signed(from_q28(START_W'(eps_r)));
    hits_new  = hits_r + COUNT_BITS'(x_e > TENTH_E);
    shots_new = shots_r + COUNT_BITS'(1);
    div_sh    = {rem_r, quo_r[DIV_W-1]};
    sh_x      = cy_r >>> it_r;
    sh_y      = cx_r >>> it_r;
    mul_sum   = '0;
    pos_sum   = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_wr_en) begin
          unique case (cfg_addr)
            CFG_START_X: start_x_nxt    = START_W'(cfg_wdata);
            CFG_START_Y: start_y_nxt    = START_W'(cfg_wdata);
            CFG_SHOTS:   shot_total_nxt = SHOT_W'(cfg_wdata);
            CFG_EPS:     eps_nxt        = EPS_W'(cfg_wdata);
            default: ;
          endcase
          if (cfg_addr == CFG_START_X || cfg_addr == CFG_START_Y) begin
            walker_x_nxt = $signed(from_q28(start_x_nxt));
            walker_y_nxt = $signed(from_q28(start_y_nxt));
          end
        end else if (accept) begin
          angle_nxt = in_tdata[ANGLE_BITS-1:0];
          x_nxt = walker_x_r;
          y_nxt = walker_y_r;
          // Fold the walker back into the domain
          if (wy_e < 0) y_nxt = sat_pos(PROD_W'(-wy_e));
          else if (wy_e > FOUR_E) y_nxt = POS_W'(wy_e - FOUR_E);
          else if (wy_e > ONE_E && wy_e < THREE_E && wx_e > TWO_E)
            x_nxt = POS_W'(FOUR_E - wx_e);
          state_nxt = ST_RANGE;
        end
      end

      ST_RANGE: begin
        if (x_e <= TWO_E) begin
          r_nxt      = x_r;
          corner_nxt = 1'b0;
          state_nxt  = ST_SQ_A;
        end else begin
          if (y_e < ONE_E) begin
            c1 = ONE_E - y_e;
            c2 = THREE_E - x_e;
          end else if (y_e > THREE_E) begin
            c1 = THREE_E - x_e;
            c2 = y_e - THREE_E;
          end else begin
            c1 = y_e - ONE_E;
            c2 = THREE_E - y_e;
          end
          r_nxt     = sat_pos(PROD_W'((c1 < c2) ? c1 : c2));
          state_nxt = ST_CHECK;
        end
      end

      ST_SQ_A: begin
        mul_a     = MUL_W'(ax);
        mul_b     = MUL_W'(ax);
        num_nxt   = NUM_W'(prod);
        state_nxt = ST_SQ_B;
      end

      ST_SQ_B: begin
        mul_a     = MUL_W'(ay);
        mul_b     = MUL_W'(ay);
        num_nxt   = num_r + NUM_W'(prod);
        res_nxt   = '0;
        bit_nxt   = NUM_W'(1) << (NUM_W - 2);
        state_nxt = ST_SQRT;
      end

      ST_SQRT: begin
        if (num_r >= trial) begin
          num_nxt = num_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          dval = (POS_W+1)'(res_nxt[SQ_W-1:0]) << HYP_SHIFT;
          dist_s = sat_pos(PROD_W'(dval));
          if (dist_s < r_r) r_nxt = dist_s;
          if (!corner_r) begin
            corner_nxt = 1'b1;
            state_nxt  = ST_SQ_A;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (r_r < eps_s) begin
          walker_x_nxt = $signed(from_q28(start_x_r));
          walker_y_nxt = $signed(from_q28(start_y_r));
          if ((SHOT_W+COUNT_BITS)'(shots_new) >= (SHOT_W+COUNT_BITS)'(total)) begin
            hit_out_nxt = HIT_W'(hits_new);
            quo_nxt     = {hits_new, 16'd0};
            rem_nxt     = '0;
            it_nxt      = '0;
            shots_nxt   = '0;
            hits_nxt    = '0;
            state_nxt   = ST_DIV;
          end else begin
            shots_nxt = shots_new;
            hits_nxt  = hits_new;
            state_nxt = ST_IDLE;
          end
        end else begin
          cx_nxt    = CORDIC_GAIN;
          cy_nxt    = '0;
          // Angle within the quadrant, 2^32 per turn
          cz_nxt    = Z_W'({2'b00, angle_r[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
          quad_nxt  = angle_r[ANGLE_BITS-1 -: 2];
          it_nxt    = '0;
          state_nxt = ST_CORDIC;
        end
      end

      ST_CORDIC: begin
        if (cz_r >= 0) begin
          cx_nxt = cx_r - sh_x;
          cy_nxt = cy_r + sh_y;
          cz_nxt = cz_r - atan_turn(it_r);
        end else begin
          cx_nxt = cx_r + sh_x;
          cy_nxt = cy_r - sh_y;
          cz_nxt = cz_r + atan_turn(it_r);
        end
        it_nxt = it_r + IT_W'(1);
        if (it_r == IT_W'(CORDIC_N - 1)) begin
          unique case (quad_r)
            2'd0: begin cos_nxt = cx_nxt;  sin_nxt = cy_nxt;  end
            2'd1: begin cos_nxt = -cy_nxt; sin_nxt = cx_nxt;  end
            2'd2: begin cos_nxt = -cx_nxt; sin_nxt = -cy_nxt; end
            default: begin cos_nxt = cy_nxt; sin_nxt = -cx_nxt; end
          endcase
          mstep_nxt = '0;
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        // Even steps: high part of r times sin/cos; odd steps: low part and update
        mul_a = mstep_r[0] ? MUL_W'({1'b0, r_r[14:0]}) : MUL_W'(r_r >>> 15);
        mul_b = mstep_r[1] ? MUL_W'(cos_r) : MUL_W'(sin_r);
        mstep_nxt = mstep_r + 2'd1;
        if (!mstep_r[0]) begin
          acc_nxt = prod;
        end else begin
          mul_sum = acc_r + (prod >>> 15);
          if (!mstep_r[1]) begin
            pos_sum = PROD_W'(x_r) + (mul_sum >>> 15);
            walker_x_nxt = sat_pos(pos_sum);
          end else begin
            pos_sum = PROD_W'(y_r) + (mul_sum >>> 15);
            walker_y_nxt = sat_pos(pos_sum);
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_DIV: begin
        if (div_sh >= (SHOT_W+1)'(total)) begin
          rem_nxt = SHOT_W'(div_sh - (SHOT_W+1)'(total));
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = SHOT_W'(div_sh);
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
        it_nxt = it_r + IT_W'(1);
        if (it_r == IT_W'(DIV_W - 1)) state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[HIT_W-1:0] = hit_out_r;
          out_data_nxt[HIT_W +: RATIO_W] =
            (quo_r > DIV_W'(65536)) ? RATIO_W'(65536) : RATIO_W'(quo_r);
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      start_x_r    <= '0;
      start_y_r    <= '0;
      shot_total_r <= SHOT_RESET;
      eps_r        <= EPS_RESET;
      walker_x_r   <= '0;
      walker_y_r   <= '0;
      shots_r      <= '0;
      hits_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_x_r    <= start_x_nxt;
      start_y_r    <= start_y_nxt;
      shot_total_r <= shot_total_nxt;
      eps_r        <= eps_nxt;
      walker_x_r   <= walker_x_nxt;
      walker_y_r   <= walker_y_nxt;
      shots_r      <= shots_nxt;
      hits_r       <= hits_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    r_r        <= r_nxt;
    angle_r    <= angle_nxt;
    corner_r   <= corner_nxt;
    num_r      <= num_nxt;
    res_r      <= res_nxt;
    bit_r      <= bit_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    quad_r     <= quad_nxt;
    it_r       <= it_nxt;
    sin_r      <= sin_nxt;
    cos_r      <= cos_nxt;
    mstep_r    <= mstep_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    hit_out_r  <= hit_out_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hdl/wos_step_checker.sv @@
// Port-level checks for the walk-on-spheres step core, bound to the top level.
module wos_step_checker import wos_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_wr_en,
  input logic [CFG_IDX_W-1:0]  cfg_addr,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Ratio never exceeds 1.0
  a_ratio_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[HIT_W +: RATIO_W] <= RATIO_W'(65536))
    else $error("hit ratio above cap");

  // No hits means a zero ratio
  a_ratio_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[HIT_W-1:0] == '0 |-> out_tdata[HIT_W +: RATIO_W] == '0)
    else $error("nonzero ratio without hits");

  // Ready falls after an accepted angle while the step runs
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !cfg_wr_en |=> !in_tready)
    else $error("ready right after a transfer");

endmodule

bind walk_on_spheres_step_core wos_step_checker u_wos_step_checker (.*);

@@ dv/walk_on_spheres_step_core_tb.sv @@
// Self-checking testbench for walk_on_spheres_step_core: directed table, then random runs.
`timescale 1ns / 1ps

module walk_on_spheres_step_core_tb;
  import wos_pkg::*;

  localparam longint ONE_Q   = 64'sd1 << 28;
  localparam longint POS_MAX = 8 * ONE_Q - 1;
  localparam longint POS_MIN = -8 * ONE_Q;
  localparam longint TENTH_Q = (ONE_Q + 5) / 10;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1100;

  localparam longint ATAN_TURN [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1};

  typedef struct packed {
    logic [HIT_W-1:0]   hits;
    logic [RATIO_W-1:0] ratio;
  } run_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [ANGLE_BITS-1:0] angle;
    bit                    typed;
    logic [HIT_W-1:0]      hits;
    logic [RATIO_W-1:0]    ratio;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the walker
  logic [START_W-1:0] start_x_q, start_y_q;
  logic [SHOT_W-1:0]  shot_total_q;
  logic [EPS_W-1:0]   eps_q;
  longint             walk_x, walk_y;
  logic [COUNT_BITS-1:0] shots_done, hits_so_far;

  run_result_t run_results_q[$];
  int  errors = 0;
  int  stall_cnt = 0;
  bit  no_idle = 1'b0;

  walk_on_spheres_step_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint sat_pos_q(longint v);
    return v > POS_MAX ? POS_MAX : (v < POS_MIN ? POS_MIN : v);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint corner_dist(longint dx, longint dy);
    longint unsigned ax, ay, r;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    r = root_floor(ax * ax + ay * ay);
    return r > POS_MAX ? POS_MAX : longint'(r);
  endfunction

  function automatic longint min_q(longint a, longint b);
    return a < b ? a : b;
  endfunction

  task automatic rotate(input logic [31:0] turn, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = turn[29:0];
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    case (turn[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint mul_q30(longint r, longint t);
    longint rh, rl;
    rh = r >>> 15;
    rl = r & 64'h7FFF;
    return (rh * t + ((rl * t) >>> 15)) >>> 15;
  endfunction

  function automatic void walker_home();
    walk_x = sat_pos_q(longint'(start_x_q));
    walk_y = sat_pos_q(longint'(start_y_q));
  endfunction

  function automatic void shadow_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_START_X: begin start_x_q = v[START_W-1:0]; walker_home(); end
      CFG_START_Y: begin start_y_q = v[START_W-1:0]; walker_home(); end
      CFG_SHOTS:   shot_total_q = v[SHOT_W-1:0];
      CFG_EPS:     eps_q = v[EPS_W-1:0];
      default: ;
    endcase
  endfunction

  // One walk step; returns 1 when the step ends a run
  task automatic walk_step(input logic [ANGLE_BITS-1:0] angle, output bit done,
                           output run_result_t res);
    longint x, y, r, s, c, total, ratio;
    x = walk_x;
    y = walk_y;
    done = 1'b0;
    res = '0;
    if (y < 0) y = sat_pos_q(-y);
    else if (y > 4 * ONE_Q) y -= 4 * ONE_Q;
    else if (y > ONE_Q && y < 3 * ONE_Q && x > 2 * ONE_Q) x = 4 * ONE_Q - x;

    if (x <= 2 * ONE_Q)
      r = min_q(x, min_q(corner_dist(x - 2 * ONE_Q, y - ONE_Q),
                         corner_dist(x - 2 * ONE_Q, y - 3 * ONE_Q)));
    else if (y < ONE_Q)
      r = min_q(ONE_Q - y, 3 * ONE_Q - x);
    else if (y > 3 * ONE_Q)
      r = min_q(3 * ONE_Q - x, y - 3 * ONE_Q);
    else
      r = min_q(y - ONE_Q, 3 * ONE_Q - y);
    r = sat_pos_q(r);

    if (r < longint'(eps_q)) begin
      total = shot_total_q != 0 ? shot_total_q : 1;
      if (x > TENTH_Q) hits_so_far = hits_so_far + 1'b1;
      shots_done = shots_done + 1'b1;
      walker_home();
      if (shots_done >= total) begin
        ratio = (longint'(hits_so_far) << 16) / total;
        res.hits = hits_so_far;
        res.ratio = ratio > 65536 ? 17'd65536 : ratio[RATIO_W-1:0];
        shots_done = '0;
        hits_so_far = '0;
        done = 1'b1;
      end
    end else begin
      rotate({angle, 16'h0000}, s, c);
      walk_x = sat_pos_q(x + mul_q30(r, s));
      walk_y = sat_pos_q(y + mul_q30(r, c));
    end
  endtask

  // Sender: gaps before the transfer, valid stays high across back-to-back items
  task automatic send_angle(input logic [ANGLE_BITS-1:0] angle, input bit typed,
                            input run_result_t typed_res);
    bit done;
    run_result_t res;
    if (!no_idle && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(angle);
    do @(posedge clk); while (!in_tready);
    walk_step(angle, done, res);
    if (typed) run_results_q.push_back(typed_res);
    else if (done) run_results_q.push_back(res);
  endtask

  // Registers change only with the core idle and nothing owed
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (run_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (!in_tready) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_cfg(idx, v);
  endtask

  always @(posedge clk) begin
    if (no_idle) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    run_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hits  = out_tdata[HIT_W-1:0];
      got.ratio = out_tdata[HIT_W +: RATIO_W];
      if (run_results_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hits=%0d ratio=%0d", got.hits, got.ratio);
      end else begin
        want = run_results_q.pop_front();
        if (got.hits !== want.hits || got.ratio !== want.ratio) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected hits=%0d ratio=%0d, got hits=%0d ratio=%0d",
                     want.hits, want.ratio, got.hits, got.ratio);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  stim_row_t directed[$] = '{
    '{0, CFG_START_X, 0,          16'h0000, 0, 0, 0},   // absorbed at reset start, no run end
    '{1, CFG_SHOTS,   1,          16'h0000, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'hFFFF, 1, 0, 0},   // lowered total ends run now
    '{1, CFG_START_X, 805306368,  16'h0000, 0, 0, 0},
    '{1, CFG_START_Y, 0,          16'h0000, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'h8000, 1, 1, 65536},
    '{1, CFG_SHOTS,   0,          16'h0000, 0, 0, 0},   // zero total acts as one
    '{0, CFG_START_X, 0,          16'h4000, 1, 1, 65536},
    '{1, CFG_EPS,     268435456,  16'h0000, 0, 0, 0},
    '{1, CFG_START_X, 134217728,  16'h0000, 0, 0, 0},
    '{1, CFG_START_Y, 536870912,  16'h0000, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'hC000, 1, 1, 65536},
    '{1, CFG_EPS,     0,          16'h0000, 0, 0, 0},   // only negative distance absorbs
    '{0, CFG_START_X, 0,          16'h0000, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'h4000, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'hC000, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'h1234, 0, 0, 0},
    '{1, CFG_EPS,     1,          16'h0000, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'hAAAA, 0, 0, 0},
    '{1, CFG_SHOTS,   3,          16'h0000, 0, 0, 0},
    '{1, CFG_EPS,     67108864,   16'h0000, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'h5555, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'h7FFF, 0, 0, 0},
    '{0, CFG_START_X, 0,          16'h8001, 0, 0, 0},
    '{1, CFG_SHOTS,   4194303,    16'h0000, 0, 0, 0}
  };

  initial begin
    int items;
    int n;
    run_result_t typed_res;
    start_x_q = '0;
    start_y_q = '0;
    shot_total_q = SHOT_RESET;
    eps_q = EPS_RESET;
    shots_done = '0;
    hits_so_far = '0;
    walker_home();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        typed_res.hits = directed[i].hits;
        typed_res.ratio = directed[i].ratio;
        send_angle(directed[i].angle, directed[i].typed, typed_res);
      end
    end

    items = 0;
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0: write_reg(CFG_START_X, CFG_DATA_W'(0));
          1: write_reg(CFG_START_X, CFG_DATA_W'(805306368));
          default: write_reg(CFG_START_X, CFG_DATA_W'($urandom_range(805306368)));
        endcase
      end
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0: write_reg(CFG_START_Y, CFG_DATA_W'(0));
          1: write_reg(CFG_START_Y, CFG_DATA_W'(805306368));
          default: write_reg(CFG_START_Y, CFG_DATA_W'($urandom_range(805306368)));
        endcase
      end
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(9))
          0: write_reg(CFG_SHOTS, CFG_DATA_W'(0));
          1: write_reg(CFG_SHOTS, CFG_DATA_W'($urandom_range(4194303)));
          default: write_reg(CFG_SHOTS, CFG_DATA_W'($urandom_range(1, 6)));
        endcase
      end
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(9))
          0: write_reg(CFG_EPS, CFG_DATA_W'(268435456));
          1: write_reg(CFG_EPS, CFG_DATA_W'($urandom_range(1, 268435456)));
          default: write_reg(CFG_EPS, CFG_DATA_W'($urandom_range(4194304, 134217728)));
        endcase
      end
      n = $urandom_range(10, 60);
      repeat (n) begin
        no_idle = (items >= 400 && items < 600);
        send_angle(ANGLE_BITS'($urandom_range(16'hFFFF)), 1'b0, '0);
        items++;
      end
    end
    no_idle = 1'b0;

    in_tvalid <= 1'b0;
    while (run_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && run_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
